[hw/rtl/rcpwm_pkg.sv]
// shared types, constants and codes of the rc pwm decoder
`default_nettype none

package rcpwm_pkg;

  // field widths
  localparam int unsigned NUM_CH  = 4;
  localparam int unsigned CH_W    = 2;
  localparam int unsigned TS_W    = 16;
  localparam int unsigned OFF_W   = 15;
  localparam int unsigned THR_W   = 14;
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDAT_W  = 16;
  localparam int unsigned Q_W     = 15;
  localparam int unsigned PROD_W  = TS_W + Q_W;
  localparam int unsigned CNT_W   = 4;

  // scaling constants
  localparam logic [Q_W-1:0]           THROTTLE_FULL = 15'd10000;
  localparam logic [Q_W-1:0]           AXIS_FULL     = 15'd20000;
  localparam logic signed [AXIS_W:0]   AXIS_LOW      = -17'sd10000;
  localparam logic signed [AXIS_W:0]   AXIS_SAT_HI   = 17'sd20000;
  localparam logic signed [AXIS_W:0]   AXIS_SAT_LO   = -17'sd20000;

  // register reset values
  localparam logic [TS_W-1:0] MIN_RESET = 16'd2000;
  localparam logic [TS_W-1:0] MAX_RESET = 16'd4000;

  // item modes
  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_POLL = 1'b1;

  // channel codes
  localparam logic [CH_W-1:0] CH_THROTTLE = 2'd0;
  localparam logic [CH_W-1:0] CH_X        = 2'd1;
  localparam logic [CH_W-1:0] CH_Y        = 2'd2;
  localparam logic [CH_W-1:0] CH_Z        = 2'd3;

  // configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_MIN_PULSE = 3'd0,
    CFG_MAX_PULSE = 3'd1,
    CFG_X_OFFSET  = 3'd2,
    CFG_Y_OFFSET  = 3'd3,
    CFG_Z_OFFSET  = 3'd4
  } cfg_idx_t;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [TS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[hw/rtl/rcpwm_if.sv]
// valid/ready channel interfaces of the rc pwm decoder
`default_nettype none

// input items: edges and polls
interface rcpwm_in_if;
  import rcpwm_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CH_W-1:0]   channel;
  logic [TS_W-1:0]   timestamp;
  modport source (output valid, mode, channel, timestamp, input ready);
  modport sink (input valid, mode, channel, timestamp, output ready);
endinterface

// decoded results
interface rcpwm_out_if;
  import rcpwm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     status;
  logic [THR_W-1:0]         throttle_pct;
  logic signed [AXIS_W-1:0] x_axis_pct;
  logic signed [AXIS_W-1:0] y_axis_pct;
  logic signed [AXIS_W-1:0] z_axis_pct;
  modport source (output valid, status, throttle_pct, x_axis_pct, y_axis_pct, z_axis_pct,
                  input ready);
  modport sink (input valid, status, throttle_pct, x_axis_pct, y_axis_pct, z_axis_pct,
                output ready);
endinterface

// register writes
interface rcpwm_cfg_if;
  import rcpwm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [CDAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/rcpwm_div.sv]
// restoring serial divider, one quotient bit per cycle
`default_nettype none

module rcpwm_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rcpwm_pkg::div_req_t req,
  output rcpwm_pkg::div_rsp_t      rsp
);
  import rcpwm_pkg::*;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(Q_W - 1);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TS_W-1:0]   rem_r, rem_nxt;
  logic [Q_W-1:0]    dvd_r, dvd_nxt;
  logic [Q_W-1:0]    q_r, q_nxt;
  logic [TS_W-1:0]   dvs_r, dvs_nxt;
  logic [TS_W:0]     trial;
  logic [TS_W:0]     diff;
  logic              fits;

  // one trial subtraction of the shifted remainder
  assign trial = {rem_r, dvd_r[Q_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  // step sequencing; the top half of the dividend is already below the divisor
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      rem_nxt = req.dividend[PROD_W-1:Q_W];
      dvd_nxt = req.dividend[Q_W-1:0];
      dvs_nxt = req.divisor;
    end else if (run_r) begin
      rem_nxt = fits ? diff[TS_W-1:0] : trial[TS_W-1:0];
      q_nxt   = {q_r[Q_W-2:0], fits};
      dvd_nxt = {dvd_r[Q_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

`ifndef SYNTHESIS
  a_no_start_while_running: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> !req.start) else $error("divider restarted mid-division");
  a_done_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held longer than one cycle");
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> rem_r < dvs_r) else $error("partial remainder not below divisor");
`endif

endmodule

`default_nettype wire

[hw/rtl/rc_pwm_four_channel_decoder.sv]
// four-channel rc pwm pulse decoder with a shared serial divider
// Usage:
//   in_ch takes edge beats (mode 0: channel and timer timestamp) and poll beats
//   (mode 1). An edge beat is absorbed and gives no result.
//   A poll beat gives one out_ch beat: status 1 with throttle and axes in
//   hundredths of a percent, or status 0 with zero fields when a channel is
//   not fresh, a width is out of range or max is not above min.
//   cfg_ch writes registers 0..4 (min, max, x, y, z offset); ready is always
//   high and indexes beyond four are dropped.
// Timing:
//   in_ch.ready is high only while the sequencer is idle. A busy poll goes
//   from the check state straight to the output state. A valid poll goes
//   through the check state, then per channel a multiply state and a divide
//   state, then the output state; the single one-bit-per-cycle divider is
//   shared by all four channels. The result sits in an output register; if
//   out_ch stalls, edge beats are still taken, and a following poll waits at
//   its end until the register frees.
// Reset: stamps zero, fresh marks clear, min 2000, max 4000, offsets zero.
`default_nettype none

module rc_pwm_four_channel_decoder (
  input wire logic    clk,
  input wire logic    rst_n,
  rcpwm_in_if.sink    in_ch,
  rcpwm_out_if.source out_ch,
  rcpwm_cfg_if.sink   cfg_ch
);
  import rcpwm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_MUL   = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t                    state_r, state_nxt;
  logic [TS_W-1:0]           min_r, max_r;
  logic signed [OFF_W-1:0]   xoff_r, yoff_r, zoff_r;
  logic [TS_W-1:0]           newest_r [NUM_CH];
  logic [TS_W-1:0]           prev_r [NUM_CH];
  logic [NUM_CH-1:0]         fresh_r;
  logic [CH_W-1:0]           idx_r;
  logic                      start_r;
  logic [PROD_W-1:0]         prod_r;
  logic                      res_ok_r;
  logic [THR_W-1:0]          res_thr_r;
  logic signed [AXIS_W-1:0]  res_x_r, res_y_r, res_z_r;
  logic                      out_valid_r;
  logic                      out_status_r;
  logic [THR_W-1:0]          out_thr_r;
  logic signed [AXIS_W-1:0]  out_x_r, out_y_r, out_z_r;

  logic [TS_W-1:0]           width [NUM_CH];
  logic [NUM_CH-1:0]         in_range;
  logic                      all_ok;
  logic [TS_W-1:0]           span;
  logic [TS_W-1:0]           d_sel;
  logic [Q_W-1:0]            k_sel;
  logic signed [OFF_W-1:0]   off_sel;
  logic signed [AXIS_W-1:0]  axis_res;
  logic                      in_acc;
  logic                      out_load;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  // axis mapping: low end, plus scaled width, minus trim, clipped
  function automatic logic signed [AXIS_W-1:0] axis_scale(
    input logic [Q_W-1:0] q, input logic signed [OFF_W-1:0] off);
    logic signed [AXIS_W:0] v;
    v = AXIS_LOW + signed'({2'b00, q}) - signed'({{(AXIS_W+1-OFF_W){off[OFF_W-1]}}, off});
    if (v > AXIS_SAT_HI) begin
      v = AXIS_SAT_HI;
    end else if (v < AXIS_SAT_LO) begin
      v = AXIS_SAT_LO;
    end
    return v[AXIS_W-1:0];
  endfunction

  // per-channel modular widths and range checks
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      width[i]    = newest_r[i] - prev_r[i];
      in_range[i] = (width[i] >= min_r) && (width[i] <= max_r);
    end
  end

  assign all_ok  = (max_r > min_r) && (&fresh_r) && (&in_range);
  assign span    = max_r - min_r;
  assign d_sel   = width[idx_r] - min_r;
  assign k_sel   = (idx_r == CH_THROTTLE) ? THROTTLE_FULL : AXIS_FULL;

  // trim of the axis being finished
  always_comb begin
    unique case (idx_r)
      CH_X:    off_sel = xoff_r;
      CH_Y:    off_sel = yoff_r;
      CH_Z:    off_sel = zoff_r;
      default: off_sel = '0;
    endcase
  end

  assign axis_res = axis_scale(div_rsp.quotient, off_sel);

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // shared divider
  assign div_req.start    = start_r;
  assign div_req.dividend = prod_r;
  assign div_req.divisor  = span;

  rcpwm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_ch.mode == MODE_POLL) state_nxt = S_CHECK;
      end
      S_CHECK: state_nxt = all_ok ? S_MUL : S_OUT;
      S_MUL:   state_nxt = S_DIV;
      S_DIV: begin
        if (div_rsp.done) state_nxt = (idx_r == CH_Z) ? S_OUT : S_MUL;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state, configuration and channel stamps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      min_r       <= MIN_RESET;
      max_r       <= MAX_RESET;
      xoff_r      <= '0;
      yoff_r      <= '0;
      zoff_r      <= '0;
      fresh_r     <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        newest_r[i] <= '0;
        prev_r[i]   <= '0;
      end
    end else begin
      state_r <= state_nxt;
      start_r <= (state_r == S_MUL);
      // register writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.index)
          CFG_MIN_PULSE: min_r  <= cfg_ch.data;
          CFG_MAX_PULSE: max_r  <= cfg_ch.data;
          CFG_X_OFFSET:  xoff_r <= cfg_ch.data[OFF_W-1:0];
          CFG_Y_OFFSET:  yoff_r <= cfg_ch.data[OFF_W-1:0];
          CFG_Z_OFFSET:  zoff_r <= cfg_ch.data[OFF_W-1:0];
          default: ;
        endcase
      end
      // edge beat shifts the stamp pair
      if (in_acc && in_ch.mode == MODE_EDGE) begin
        prev_r[in_ch.channel]   <= newest_r[in_ch.channel];
        newest_r[in_ch.channel] <= in_ch.timestamp;
        fresh_r[in_ch.channel]  <= 1'b1;
      end
      // channel walk
      if (state_r == S_CHECK) begin
        idx_r <= CH_THROTTLE;
      end else if (state_r == S_DIV && div_rsp.done) begin
        idx_r <= idx_r + 1'b1;
      end
      // hand the result over
      if (out_load) begin
        out_valid_r <= 1'b1;
        if (res_ok_r) fresh_r <= '0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // product, result scratch and output payload
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      prod_r <= PROD_W'(d_sel) * PROD_W'(k_sel);
    end
    if (state_r == S_CHECK) begin
      res_ok_r  <= all_ok;
      res_thr_r <= '0;
      res_x_r   <= '0;
      res_y_r   <= '0;
      res_z_r   <= '0;
    end
    if (state_r == S_DIV && div_rsp.done) begin
      case (idx_r)
        CH_THROTTLE: res_thr_r <= div_rsp.quotient[THR_W-1:0];
        CH_X:        res_x_r   <= axis_res;
        CH_Y:        res_y_r   <= axis_res;
        default:     res_z_r   <= axis_res;
      endcase
    end
    if (out_load) begin
      out_status_r <= res_ok_r;
      out_thr_r    <= res_thr_r;
      out_x_r      <= res_x_r;
      out_y_r      <= res_y_r;
      out_z_r      <= res_z_r;
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.throttle_pct = out_thr_r;
  assign out_ch.x_axis_pct   = out_x_r;
  assign out_ch.y_axis_pct   = out_y_r;
  assign out_ch.z_axis_pct   = out_z_r;

`ifndef SYNTHESIS
  a_busy_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.status |-> out_ch.throttle_pct == '0 && out_ch.x_axis_pct == '0
      && out_ch.y_axis_pct == '0 && out_ch.z_axis_pct == '0)
    else $error("busy result carries nonzero fields");
  a_throttle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status |-> out_ch.throttle_pct <= THROTTLE_FULL[THR_W-1:0])
    else $error("throttle above full scale");
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV) else $error("divider finished outside divide phase");
`endif

endmodule

`default_nettype wire
